FILE: src/eps_pkg.sv
// shared types and constants for the edge proximity search block
`timescale 1ns / 1ps

package eps_pkg;

   localparam int POS_W = 10;
   localparam int PIX_W = 8;
   localparam int RAD_W = 5;

   localparam int DEF_IMG_WIDTH  = 1024;
   localparam int DEF_IMG_HEIGHT = 768;
   localparam int DEF_MAX_RADIUS = 31;

   localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd240;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // sequencer status toward the top level
   typedef struct packed {
      logic busy;
      logic res_valid;
      logic res_found;
   } eps_seq_status_type;

endpackage

FILE: src/edge_proximity_search.sv
// edge proximity search top level: image load, threshold register, result register
// query: its window is clipped and its base address formed, then its pixels are read up
//   to the first hit (the whole clipped window when none hits, up to 63 x 63), one per
//   cycle through the single image read port; an empty window skips the scan
// flow: one query at a time, the next item taken only after the output register takes
//   its result, so a stalled result holds it up; writes give no result
// reset: synchronous, active high; sequencer and result idle, threshold 240, image kept
`timescale 1ns / 1ps

module edge_proximity_search import eps_pkg::*; #(
   parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
   parameter int IMG_HEIGHT = DEF_IMG_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic             clock,
   input  logic             reset,
   // item input
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_cmd,
   input  logic [POS_W-1:0] req_pos_x,
   input  logic [POS_W-1:0] req_pos_y,
   input  logic [PIX_W-1:0] req_pixel_value,
   input  logic [RAD_W-1:0] req_radius,
   // result output
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_edge_found,
   // threshold register
   input  logic             csr_wr_en,
   input  logic [PIX_W-1:0] csr_wr_data
);

   localparam int DEPTH  = IMG_WIDTH * IMG_HEIGHT;
   localparam int AW     = $clog2(DEPTH);
   localparam int XY_MAX = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
   localparam int CW     = (($clog2(XY_MAX) > POS_W) ? $clog2(XY_MAX) : POS_W) + 1;

   eps_seq_status_type seq_status;

   logic             req_accept;
   logic             query_start;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [PIX_W-1:0] rd_data;
   logic             rd_vld;
   logic             res_ready;
   logic             res_take;

   logic [PIX_W-1:0] threshold_ff, threshold_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;

   // input side stalls while a query is in the sequencer, until its result is taken
   assign req_stall   = seq_status.busy;
   assign req_accept  = req_valid && !req_stall;
   assign query_start = req_accept && (req_cmd == CMD_QUERY);

   // writes outside the image are dropped
   assign wr_en   = req_accept && (req_cmd == CMD_WRITE) &&
                    (CW'(req_pos_x) < CW'(IMG_WIDTH)) &&
                    (CW'(req_pos_y) < CW'(IMG_HEIGHT));
   assign wr_addr = AW'(req_pos_y) * AW'(IMG_WIDTH) + AW'(req_pos_x);

   // the threshold is to change only while the block is idle; the block does not enforce it
   assign threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;

   // output register frees the sequencer as soon as the slot is empty or drains
   assign res_ready    = !rsp_valid_ff || !rsp_stall;
   assign res_take     = seq_status.res_valid && res_ready;
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);
   assign rsp_found_in = res_take ? seq_status.res_found : rsp_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_found = rsp_found_ff;

   eps_pixel_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rd_vld  (rd_vld)
   );

   eps_window_seq #(
      .IMG_WIDTH  (IMG_WIDTH),
      .IMG_HEIGHT (IMG_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (query_start),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .radius    (req_radius),
      .threshold (threshold_ff),
      .res_ready (res_ready),
      .status    (seq_status),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rd_vld    (rd_vld)
   );

endmodule

FILE: src/eps_pixel_ram.sv
// edge image storage, one write port and one registered read port
`timescale 1ns / 1ps

module eps_pixel_ram import eps_pkg::*; #(
   parameter int DEPTH = DEF_IMG_WIDTH * DEF_IMG_HEIGHT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [PIX_W-1:0] rd_data,
   output logic             rd_vld
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_vld  = rd_vld_ff;

endmodule

FILE: src/eps_window_seq.sv
// window scan sequencer: clipping, address walk and threshold compare
`timescale 1ns / 1ps

module eps_window_seq import eps_pkg::*; #(
   parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
   parameter int IMG_HEIGHT = DEF_IMG_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   localparam int AW     = $clog2(IMG_WIDTH * IMG_HEIGHT),
   localparam int XY_MAX = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT,
   localparam int CW     = (($clog2(XY_MAX) > POS_W) ? $clog2(XY_MAX) : POS_W) + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [POS_W-1:0]   pos_x,
   input  logic [POS_W-1:0]   pos_y,
   input  logic [RAD_W-1:0]   radius,
   input  logic [PIX_W-1:0]   threshold,
   input  logic               res_ready,
   output eps_seq_status_type status,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   input  logic [PIX_W-1:0]   rd_data,
   input  logic               rd_vld
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLIP,
      ST_BASE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   localparam logic [CW-1:0] X_LIM   = CW'(IMG_WIDTH - 1);
   localparam logic [CW-1:0] Y_LIM   = CW'(IMG_HEIGHT - 1);
   localparam logic [CW-1:0] RAD_LIM = CW'(MAX_RADIUS);
   localparam logic [AW-1:0] ROW_STEP = AW'(IMG_WIDTH);

   state_type     state_ff, state_in;
   logic [CW-1:0] px_ff, px_in, py_ff, py_in, rad_ff, rad_in;
   logic [CW-1:0] c0_ff, c0_in, c1_ff, c1_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [AW-1:0] addr_ff, addr_in, rowbase_ff, rowbase_in;
   logic          found_ff, found_in;

   logic [CW-1:0] rad_req;
   logic [CW-1:0] x_sum, y_sum;
   logic [AW-1:0] base_addr;
   logic          hit;

   assign rad_req   = CW'(radius);
   assign x_sum     = px_ff + rad_ff;
   assign y_sum     = py_ff + rad_ff;
   assign base_addr = AW'(r0_ff) * ROW_STEP + AW'(c0_ff);
   // the one compare unit, fed by the registered read
   assign hit       = rd_vld && (rd_data >= threshold);

   always_comb begin
      state_in   = state_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      rad_in     = rad_ff;
      c0_in      = c0_ff;
      c1_in      = c1_ff;
      r0_in      = r0_ff;
      r1_in      = r1_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      addr_in    = addr_ff;
      rowbase_in = rowbase_ff;
      found_in   = found_ff;
      rd_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               px_in    = CW'(pos_x);
               py_in    = CW'(pos_y);
               rad_in   = (rad_req > RAD_LIM) ? RAD_LIM : rad_req;
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            c0_in    = (px_ff < rad_ff) ? '0 : px_ff - rad_ff;
            r0_in    = (py_ff < rad_ff) ? '0 : py_ff - rad_ff;
            c1_in    = (x_sum > X_LIM) ? X_LIM : x_sum;
            r1_in    = (y_sum > Y_LIM) ? Y_LIM : y_sum;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            if ((c0_ff > c1_ff) || (r0_ff > r1_ff)) begin
               found_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               col_in     = c0_ff;
               row_in     = r0_ff;
               addr_in    = base_addr;
               rowbase_in = base_addr;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               found_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               rd_en = 1'b1;
               if (col_ff == c1_ff) begin
                  if (row_ff == r1_ff) begin
                     state_in = ST_DRAIN;
                  end else begin
                     row_in     = row_ff + CW'(1);
                     col_in     = c0_ff;
                     addr_in    = rowbase_ff + ROW_STEP;
                     rowbase_in = rowbase_ff + ROW_STEP;
                  end
               end else begin
                  col_in  = col_ff + CW'(1);
                  addr_in = addr_ff + AW'(1);
               end
            end
         end
         ST_DRAIN: begin
            // last read of the window lands here
            found_in = hit;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
      px_ff      <= px_in;
      py_ff      <= py_in;
      rad_ff     <= rad_in;
      c0_ff      <= c0_in;
      c1_ff      <= c1_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      addr_ff    <= addr_in;
      rowbase_ff <= rowbase_in;
   end

   assign rd_addr          = addr_ff;
   assign status.busy      = (state_ff != ST_IDLE);
   assign status.res_valid = (state_ff == ST_FINISH);
   assign status.res_found = found_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == ST_IDLE))
      else $error("query started while sequencer busy");

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (col_ff >= c0_ff && col_ff <= c1_ff &&
                                 row_ff >= r0_ff && row_ff <= r1_ff))
      else $error("scan position left the clipped window");

   a_addr_track: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (addr_ff == rowbase_ff + AW'(col_ff - c0_ff)))
      else $error("read address out of step with column counter");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (status.res_valid && !res_ready) |=> (status.res_valid && $stable(found_ff)))
      else $error("pending result dropped or changed");

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for edge_proximity_search: shadow image, directed table, random queries
`timescale 1ns / 1ps

module tb_top;
   import eps_pkg::*;

   localparam int IMG_W      = DEF_IMG_WIDTH;
   localparam int IMG_H      = DEF_IMG_HEIGHT;
   localparam int IMG_PIXELS = IMG_W * IMG_H;

   // worst run: ~320 queries at a full 63 x 63 scan plus a few tens of thousands of
   // loads, all under stalls and gaps; the limit sits several times above that
   localparam int RUN_LIMIT     = 5_000_000;
   // settling time after the last result, so that trailing loads are done
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_ITEMS   = 54;
   // long receiver hold-off, started once after this many results
   localparam int HOLD_AFTER    = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int NUM_SPOTS     = 6;
   localparam int NUM_PHASES    = 6;

   // one directed row: known set means the expected answer is typed in
   typedef struct packed {
      logic             cmd;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [PIX_W-1:0] val;
      logic [RAD_W-1:0] rad;
      logic             known;
      logic             found;
   } probe_row_type;

   localparam int PROBE_ROWS = 22;
   localparam probe_row_type PROBE_TABLE [PROBE_ROWS] = '{
      // strongest pixel in the top left corner, radius zero sees only it
      '{CMD_WRITE, 10'd0,    10'd0,    8'd255, 5'd0,  1'b0, 1'b0},
      '{CMD_QUERY, 10'd0,    10'd0,    8'd0,   5'd0,  1'b1, 1'b1},
      // one below the threshold
      '{CMD_WRITE, 10'd0,    10'd0,    8'd239, 5'd31, 1'b0, 1'b0},
      '{CMD_QUERY, 10'd0,    10'd0,    8'd0,   5'd0,  1'b1, 1'b0},
      // exactly at the threshold
      '{CMD_WRITE, 10'd0,    10'd0,    8'd240, 5'd0,  1'b0, 1'b0},
      '{CMD_QUERY, 10'd0,    10'd0,    8'd0,   5'd0,  1'b1, 1'b1},
      // bottom right corner, zero then full strength
      '{CMD_WRITE, 10'd1023, 10'd767,  8'd0,   5'd0,  1'b0, 1'b0},
      '{CMD_QUERY, 10'd1023, 10'd767,  8'd0,   5'd0,  1'b1, 1'b0},
      '{CMD_WRITE, 10'd1023, 10'd767,  8'd255, 5'd0,  1'b0, 1'b0},
      '{CMD_QUERY, 10'd1023, 10'd767,  8'd0,   5'd0,  1'b1, 1'b1},
      // loads below the image are dropped
      '{CMD_WRITE, 10'd0,    10'd768,  8'd255, 5'd0,  1'b0, 1'b0},
      '{CMD_WRITE, 10'd1023, 10'd1023, 8'd255, 5'd31, 1'b0, 1'b0},
      // centre far below the image: nothing left after clipping
      '{CMD_QUERY, 10'd0,    10'd1023, 8'd0,   5'd31, 1'b1, 1'b0},
      '{CMD_QUERY, 10'd1023, 10'd1023, 8'd255, 5'd31, 1'b1, 1'b0},
      // centre just below, radius zero: empty window
      '{CMD_QUERY, 10'd1023, 10'd768,  8'd0,   5'd0,  1'b1, 1'b0},
      // centre below, window clipped to the last row only
      '{CMD_QUERY, 10'd1023, 10'd798,  8'd0,   5'd31, 1'b0, 1'b0},
      // windows clipped at the corners, the first two at the largest radius
      '{CMD_QUERY, 10'd0,    10'd0,    8'd0,   5'd31, 1'b0, 1'b0},
      '{CMD_QUERY, 10'd1023, 10'd0,    8'd0,   5'd31, 1'b0, 1'b0},
      '{CMD_QUERY, 10'd0,    10'd767,  8'd0,   5'd5,  1'b0, 1'b0},
      // pixel value on a query is ignored
      '{CMD_QUERY, 10'd512,  10'd384,  8'd255, 5'd1,  1'b0, 1'b0},
      '{CMD_QUERY, 10'd1023, 10'd767,  8'd0,   5'd31, 1'b1, 1'b1},
      '{CMD_QUERY, 10'd0,    10'd0,    8'd255, 5'd0,  1'b1, 1'b1}
   };

   // threshold per random phase; the fifth one is drawn at run time
   localparam int PHASE_LEVELS [NUM_PHASES] = '{0, 255, 240, 128, 0, 200};

   // areas where queries and loads cluster, so loaded pixels get reused
   localparam int SPOT_X [NUM_SPOTS] = '{0, 1023, 0, 1023, 512, 300};
   localparam int SPOT_Y [NUM_SPOTS] = '{0, 0, 767, 767, 384, 767};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_cmd = CMD_WRITE;
   logic [POS_W-1:0] req_pos_x = '0;
   logic [POS_W-1:0] req_pos_y = '0;
   logic [PIX_W-1:0] req_pixel_value = '0;
   logic [RAD_W-1:0] req_radius = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_edge_found;
   logic             csr_wr_en = 1'b0;
   logic [PIX_W-1:0] csr_wr_data = THRESHOLD_RESET;

   // shadow copy of the image and of the threshold
   logic [PIX_W-1:0] shadow_pixels [IMG_PIXELS];
   bit               shadow_loaded [IMG_PIXELS];
   logic [PIX_W-1:0] edge_level = THRESHOLD_RESET;

   // expected edge_found per accepted query, oldest first
   bit found_queue [$];
   bit want_found;

   int err_count    = 0;
   int results_seen = 0;
   int cycle_count  = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;
   // set during one phase: neither side idles
   bit quiet        = 1'b0;

   edge_proximity_search uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pixel_value (req_pixel_value),
      .req_radius      (req_radius),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_edge_found  (rsp_edge_found),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // window around the centre, clipped to the image; empty when r0 > r1
   function automatic void window_bounds(input int cx, input int cy, input int rad,
                                         output int r0, output int r1,
                                         output int c0, output int c1);
      int r;
      r  = (rad > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : rad;
      r0 = (cy - r < 0) ? 0 : cy - r;
      r1 = (cy + r > IMG_H - 1) ? IMG_H - 1 : cy + r;
      c0 = (cx - r < 0) ? 0 : cx - r;
      c1 = (cx + r > IMG_W - 1) ? IMG_W - 1 : cx + r;
   endfunction

   // does any pixel of the window reach the threshold
   function automatic bit predict_edge(input int cx, input int cy, input int rad);
      int r0, r1, c0, c1;
      window_bounds(cx, cy, rad, r0, r1, c0, c1);
      for (int row = r0; row <= r1; row++)
         for (int col = c0; col <= c1; col++)
            if (shadow_pixels[row * IMG_W + col] >= edge_level) return 1'b1;
      return 1'b0;
   endfunction

   // mostly weak pixels, a few strong ones, some exactly zero or full scale
   function automatic logic [PIX_W-1:0] pick_strength();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return 8'd255;
      if (roll < 4) return PIX_W'($urandom_range(200, 254));
      if (roll < 7) return 8'd0;
      return PIX_W'($urandom_range(1, 199));
   endfunction

   task automatic report_mismatch(input string what, input bit got, input bit want);
      err_count++;
      $display("tb_top: mismatch, %s: edge_found %0b, expected %0b, cycle %0d",
               what, got, want, cycle_count);
   endtask

   // offer one item, hold it until accepted, then update the shadow state
   task automatic send_item(input bit cmd, input int x, input int y, input int val,
                            input int rad, input bit known, input bit known_found);
      int gap;
      if (!quiet && $urandom_range(0, 99) < 14) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_pos_x       <= POS_W'(x);
      req_pos_y       <= POS_W'(y);
      req_pixel_value <= PIX_W'(val);
      req_radius      <= RAD_W'(rad);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == CMD_WRITE) begin
         // loads outside the image leave it untouched
         if (x < IMG_W && y < IMG_H) begin
            shadow_pixels[y * IMG_W + x] = PIX_W'(val);
            shadow_loaded[y * IMG_W + x] = 1'b1;
         end
      end else begin
         found_queue.insert(found_queue.size(),
                            known ? known_found : predict_edge(x, y, rad));
      end
   endtask

   // load every pixel of the window that was never written, then query
   task automatic issue_query(input int cx, input int cy, input int rad, input int val,
                              input bit known, input bit known_found);
      int r0, r1, c0, c1;
      window_bounds(cx, cy, rad, r0, r1, c0, c1);
      for (int row = r0; row <= r1; row++)
         for (int col = c0; col <= c1; col++)
            if (!shadow_loaded[row * IMG_W + col])
               send_item(CMD_WRITE, col, row, pick_strength(), $urandom_range(0, 31),
                         1'b0, 1'b0);
      send_item(CMD_QUERY, cx, cy, val, rad, known, known_found);
   endtask

   // stop offering, wait for every result, then for trailing loads to finish
   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (found_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_edge_level(input int level);
      drain_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= PIX_W'(level);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      edge_level  = PIX_W'(level);
   endtask

   // random mix: clustered queries and loads, a few loads and centres off the image
   task automatic run_random_phase(input int count);
      int done_items, spot, x, y, rad, roll;
      done_items = 0;
      while (done_items < count) begin
         spot = $urandom_range(0, NUM_SPOTS - 1);
         if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 99) < 8) begin
               // dropped load below the image, does not count
               send_item(CMD_WRITE, $urandom_range(0, 1023), $urandom_range(768, 1023),
                         $urandom_range(0, 255), $urandom_range(0, 31), 1'b0, 1'b0);
            end else begin
               x = SPOT_X[spot] + $urandom_range(0, 40) - 20;
               y = SPOT_Y[spot] + $urandom_range(0, 40) - 20;
               x = (x < 0) ? 0 : (x > IMG_W - 1) ? IMG_W - 1 : x;
               y = (y < 0) ? 0 : (y > IMG_H - 1) ? IMG_H - 1 : y;
               send_item(CMD_WRITE, x, y, pick_strength(), $urandom_range(0, 31),
                         1'b0, 1'b0);
               done_items++;
            end
         end else begin
            // mostly small windows, some mid, a few up to the largest radius
            roll = $urandom_range(0, 99);
            rad  = (roll < 55) ? $urandom_range(0, 3) :
                   (roll < 80) ? $urandom_range(4, 12) : $urandom_range(13, 31);
            if ($urandom_range(0, 99) < 5) begin
               // centre so far below that the window is empty
               x = $urandom_range(0, 1023);
               y = $urandom_range(800, 1023);
            end else begin
               x = SPOT_X[spot] + $urandom_range(0, 8) - 4;
               y = SPOT_Y[spot] + $urandom_range(0, 8) - 4;
               if (SPOT_Y[spot] == IMG_H - 1 && $urandom_range(0, 99) < 20)
                  y = IMG_H - 1 + $urandom_range(1, 40);
               x = (x < 0) ? 0 : (x > IMG_W - 1) ? IMG_W - 1 : x;
               y = (y < 0) ? 0 : y;
            end
            issue_query(x, y, rad, $urandom_range(0, 255), 1'b0, 1'b0);
            done_items++;
         end
      end
   endtask

   // result side: check each result against the oldest expected query answer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (found_queue.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_edge_found, 1'b0);
            end else begin
               want_found = found_queue.pop_front();
               if (rsp_edge_found !== want_found)
                  report_mismatch("query answer", rsp_edge_found, want_found);
            end
            results_seen++;
         end
      end
   end

   // receiver stall, with one long hold-off while the sender keeps offering
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 14);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      probe_row_type row;
      int level;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset threshold, written explicitly
      set_edge_level(THRESHOLD_RESET);
      for (int i = 0; i < PROBE_ROWS; i++) begin
         row = PROBE_TABLE[i];
         if (row.cmd == CMD_QUERY)
            issue_query(row.x, row.y, row.rad, row.val, row.known, row.found);
         else
            send_item(CMD_WRITE, row.x, row.y, row.val, row.rad, 1'b0, 1'b0);
      end

      // random phases, each under its own threshold; the fourth runs without idling
      for (int p = 0; p < NUM_PHASES; p++) begin
         level = (p == 4) ? $urandom_range(1, 254) : PHASE_LEVELS[p];
         set_edge_level(level);
         quiet = (p == 3);
         run_random_phase(PHASE_ITEMS);
         quiet = 1'b0;
      end

      drain_block();
      if (err_count == 0 && found_queue.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
